[rtl/hsvrgb_pkg.sv]
// Shared constants, types and helpers for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int HUE_FRAC_BITS = 4;

    localparam int HUE_W = 16;
    localparam int SAT_W = 9;
    localparam int BRT_W = 9;
    localparam int CH_W  = 8;

    localparam int IN_TDATA_W  = ((HUE_W + SAT_W + BRT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * CH_W + 7) / 8) * 8;

    localparam int SECTOR_W = 60 << HUE_FRAC_BITS;
    localparam int CIRCLE_W = 360 << HUE_FRAC_BITS;

    localparam int HUE_SPAN = 1 << (HUE_W - 1);
    localparam int HUE_BIAS = CIRCLE_W * ((HUE_SPAN + CIRCLE_W - 1) / CIRCLE_W);
    localparam int X_W      = $clog2(HUE_BIAS + HUE_SPAN);

    localparam int SH1  = HUE_FRAC_BITS + 2;
    localparam int Y_W  = X_W - SH1;
    localparam int K1   = Y_W + 4;
    localparam int M1   = (1 << K1) / 15 + 1;
    localparam int M1_W = $clog2(M1 + 1);
    localparam int P1_W = Y_W + M1_W;

    localparam int Q_W  = Y_W - 3;
    localparam int K2   = Q_W + 3;
    localparam int M2   = (1 << K2) / 6 + 1;
    localparam int M2_W = $clog2(M2 + 1);
    localparam int P2_W = Q_W + M2_W;
    localparam int QQ_W = Q_W - 2;

    localparam int SEC_W = 3;
    localparam int OFF_W = $clog2(SECTOR_W + 1);

    localparam int SCALE    = 255;
    localparam int FULL_SAT = 256;
    localparam int LVL_SH   = 8;
    localparam int MIN_SH   = 16;
    localparam int VS_W     = BRT_W + 8;
    localparam int MUL_W    = VS_W + SAT_W;
    localparam int LVL_W    = MUL_W - MIN_SH;

    localparam int P_W   = MUL_W + OFF_W;
    localparam int RSH   = MIN_SH + SH1;
    localparam int T_W   = P_W - RSH;
    localparam int K3    = T_W + 4;
    localparam int M3    = (1 << K3) / 15 + 1;
    localparam int M3_W  = $clog2(M3 + 1);
    localparam int P3_W  = T_W + M3_W;
    localparam int RP_W  = T_W - 3;
    localparam int CHV_W = ((RP_W > LVL_W) ? RP_W : LVL_W) + 1;

    localparam int CH_MAX = 255;

    localparam int NSTAGE = 6;

    typedef enum logic [SEC_W-1:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    function automatic logic [CH_W-1:0] sat_ch(input logic [CHV_W-1:0] val);
        return (val > CHV_W'(CH_MAX)) ? CH_W'(CH_MAX) : val[CH_W-1:0];
    endfunction

endpackage

[rtl/hsv_to_rgb_converter.sv]
// Top level of the HSV to RGB converter.
// Throughput: one transfer per cycle while the output is not stalled; six pipeline registers with a valid bit each.
// A stalled output fills bubbles first, so input is taken until every stage holds an item.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module hsv_to_rgb_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [hsvrgb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // hue, saturation, brightness
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [hsvrgb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // red, green, blue
);
    import hsvrgb_pkg::*;

    logic [NSTAGE-1:0]        en;
    logic signed [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]         sat;
    logic [BRT_W-1:0]         brt;
    t_sector                  sector;
    logic [OFF_W-1:0]         ramp_w;
    logic [CH_W-1:0]          red;
    logic [CH_W-1:0]          green;
    logic [CH_W-1:0]          blue;

    assign hue = s_axis_tdata[HUE_W-1:0];
    assign sat = s_axis_tdata[HUE_W+SAT_W-1:HUE_W];
    assign brt = s_axis_tdata[HUE_W+SAT_W+BRT_W-1:HUE_W+SAT_W];

    hsvrgb_pipe_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_en      (en)
    );

    hsvrgb_hue_unit u_hue (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_hue    (hue),
        .o_sector (sector),
        .o_ramp_w (ramp_w)
    );

    hsvrgb_chan_unit u_chan (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_sat    (sat),
        .i_brt    (brt),
        .i_sector (sector),
        .i_ramp_w (ramp_w),
        .o_red    (red),
        .o_green  (green),
        .o_blue   (blue)
    );

    assign m_axis_tdata = OUT_TDATA_W'({blue, green, red});

endmodule

[rtl/hsvrgb_pipe_ctrl.sv]
// Valid bits and per-stage load enables of the conversion pipeline.
module hsvrgb_pipe_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    output logic                        o_s_ready,
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output logic [hsvrgb_pkg::NSTAGE-1:0] o_en
);
    import hsvrgb_pkg::*;

    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE-1:0] n_rdy;

    always_comb begin
        n_rdy[NSTAGE-1] = !r_valid[NSTAGE-1] || i_m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            n_rdy[k] = !r_valid[k] || n_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_valid[0] <= i_s_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (n_rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_en      = n_rdy;
    assign o_s_ready = n_rdy[0];
    assign o_m_valid = r_valid[NSTAGE-1];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0))
        else $error("valid bits not cleared by reset");

    a_stall_blocks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NSTAGE-1] && !i_m_ready) |-> !o_en[NSTAGE-1])
        else $error("last stage overwritten while stalled");

    a_hold_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[0] && !o_en[0]) |=> r_valid[0])
        else $error("stalled item lost in first stage");

    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[2] && !o_en[2]) |=> r_valid[2])
        else $error("stalled item lost in middle stage");

    a_advance_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NSTAGE-2] && o_en[NSTAGE-1]) |=> r_valid[NSTAGE-1])
        else $error("item dropped entering output stage");

endmodule

[rtl/hsvrgb_hue_unit.sv]
// Hue wrap, sector split and in-sector ramp weight over three stages.
module hsvrgb_hue_unit (
    input  logic                               i_clk,
    input  logic [hsvrgb_pkg::NSTAGE-1:0]      i_en,
    input  logic signed [hsvrgb_pkg::HUE_W-1:0] i_hue,
    output hsvrgb_pkg::t_sector                o_sector,
    output logic [hsvrgb_pkg::OFF_W-1:0]       o_ramp_w
);
    import hsvrgb_pkg::*;

    logic [X_W-1:0]   n_x;
    logic [Y_W-1:0]   n_y;
    logic [X_W-1:0]   r_x;
    logic [P1_W-1:0]  r_prod1;

    logic [Q_W-1:0]   n_q;
    logic [Q_W-1:0]   r_q;
    logic [P2_W-1:0]  r_prod2;
    logic [OFF_W-1:0] r_off;

    logic [QQ_W-1:0]  n_qq;
    logic [Q_W-1:0]   n_sec_full;
    logic [SEC_W-1:0] n_sec;
    t_sector          r_sector;
    logic [OFF_W-1:0] r_ramp_w;

    always_comb begin
        n_x        = X_W'(HUE_BIAS + int'(i_hue));
        n_y        = Y_W'(n_x >> SH1);
        n_q        = Q_W'(r_prod1 >> K1);
        n_qq       = QQ_W'(r_prod2 >> K2);
        n_sec_full = r_q - Q_W'(n_qq) * Q_W'(6);
        n_sec      = n_sec_full[SEC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x     <= n_x;
            r_prod1 <= P1_W'(n_y) * P1_W'(M1);
        end
        if (i_en[1]) begin
            r_q     <= n_q;
            r_prod2 <= P2_W'(n_q) * P2_W'(M2);
            r_off   <= OFF_W'(r_x - X_W'(n_q) * X_W'(SECTOR_W));
        end
        if (i_en[2]) begin
            r_sector <= t_sector'(n_sec);
            r_ramp_w <= n_sec[0] ? (OFF_W'(SECTOR_W) - r_off) : r_off;
        end
    end

    assign o_sector = r_sector;
    assign o_ramp_w = r_ramp_w;

endmodule

[rtl/hsvrgb_chan_unit.sv]
// Level products, ramp scaling and per-sector channel select with output stage.
module hsvrgb_chan_unit (
    input  logic                          i_clk,
    input  logic [hsvrgb_pkg::NSTAGE-1:0] i_en,
    input  logic [hsvrgb_pkg::SAT_W-1:0]  i_sat,
    input  logic [hsvrgb_pkg::BRT_W-1:0]  i_brt,
    input  hsvrgb_pkg::t_sector           i_sector,
    input  logic [hsvrgb_pkg::OFF_W-1:0]  i_ramp_w,
    output logic [hsvrgb_pkg::CH_W-1:0]   o_red,
    output logic [hsvrgb_pkg::CH_W-1:0]   o_green,
    output logic [hsvrgb_pkg::CH_W-1:0]   o_blue
);
    import hsvrgb_pkg::*;

    logic [VS_W-1:0]  r_vs1;
    logic [SAT_W-1:0] r_sc;

    logic [MUL_W-1:0] r_vsc2;
    logic [MUL_W-1:0] r_vmin2;
    logic [VS_W-1:0]  r_vs2;

    logic [MUL_W-1:0] r_vsc3;
    logic [LVL_W-1:0] r_max3;
    logic [LVL_W-1:0] r_min3;

    logic [P_W-1:0]   r_p4;
    t_sector          r_sec4;
    logic [LVL_W-1:0] r_max4;
    logic [LVL_W-1:0] r_min4;

    logic [T_W-1:0]   n_t;
    logic [P3_W-1:0]  r_prod5;
    t_sector          r_sec5;
    logic [LVL_W-1:0] r_max5;
    logic [LVL_W-1:0] r_min5;

    logic [CHV_W-1:0] n_ramp;
    logic [CHV_W-1:0] n_max;
    logic [CHV_W-1:0] n_min;
    logic [CHV_W-1:0] n_r;
    logic [CHV_W-1:0] n_g;
    logic [CHV_W-1:0] n_b;
    logic [CH_W-1:0]  r_red;
    logic [CH_W-1:0]  r_green;
    logic [CH_W-1:0]  r_blue;

    always_comb begin
        n_t    = T_W'(r_p4 >> RSH);
        n_ramp = CHV_W'(r_prod5 >> K3) + CHV_W'(r_min5);
        n_max  = CHV_W'(r_max5);
        n_min  = CHV_W'(r_min5);
        unique case (r_sec5)
            SEC_R_TO_Y: begin n_r = n_max;  n_g = n_ramp; n_b = n_min;  end
            SEC_Y_TO_G: begin n_r = n_ramp; n_g = n_max;  n_b = n_min;  end
            SEC_G_TO_C: begin n_r = n_min;  n_g = n_max;  n_b = n_ramp; end
            SEC_C_TO_B: begin n_r = n_min;  n_g = n_ramp; n_b = n_max;  end
            SEC_B_TO_M: begin n_r = n_ramp; n_g = n_min;  n_b = n_max;  end
            default:    begin n_r = n_max;  n_g = n_min;  n_b = n_ramp; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_vs1 <= VS_W'(i_brt) * VS_W'(SCALE);
            r_sc  <= (i_sat > SAT_W'(FULL_SAT)) ? SAT_W'(FULL_SAT) : i_sat;
        end
        if (i_en[1]) begin
            r_vsc2  <= MUL_W'(r_vs1) * MUL_W'(r_sc);
            r_vmin2 <= MUL_W'(r_vs1) * MUL_W'(SAT_W'(FULL_SAT) - r_sc);
            r_vs2   <= r_vs1;
        end
        if (i_en[2]) begin
            r_vsc3 <= r_vsc2;
            r_max3 <= LVL_W'(r_vs2 >> LVL_SH);
            r_min3 <= LVL_W'(r_vmin2 >> MIN_SH);
        end
        if (i_en[3]) begin
            r_p4   <= P_W'(r_vsc3) * P_W'(i_ramp_w);
            r_sec4 <= i_sector;
            r_max4 <= r_max3;
            r_min4 <= r_min3;
        end
        if (i_en[4]) begin
            r_prod5 <= P3_W'(n_t) * P3_W'(M3);
            r_sec5  <= r_sec4;
            r_max5  <= r_max4;
            r_min5  <= r_min4;
        end
        if (i_en[5]) begin
            r_red   <= sat_ch(n_r);
            r_green <= sat_ch(n_g);
            r_blue  <= sat_ch(n_b);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

[tb/tb_hsv_to_rgb_converter.sv]
// Self-checking testbench for hsv_to_rgb_converter: streamed pixels checked against a predictor.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;
    import hsvrgb_pkg::*;

    localparam longint DEG60  = longint'(60) << HUE_FRAC_BITS;
    localparam longint DEG360 = longint'(360) << HUE_FRAC_BITS;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [BRT_W-1:0] brt;
    } hsv_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    typedef struct {
        hsv_t pixel;
        rgb_t color;
    } pending_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // hue, saturation, brightness
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // red, green, blue

    pending_t pending_rgb[$];
    int       mismatch_count = 0;
    bit       steady = 1'b0;

    hsv_to_rgb_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [CH_W-1:0] clip_channel(input longint level);
        return (level > 255) ? CH_W'(255) : CH_W'(level);
    endfunction

    function automatic rgb_t hsv_to_rgb(input hsv_t px);
        longint  pos, off, r, s, v, top, bottom, ramp, rr, gg, bb;
        t_sector sec;
        rgb_t    c;
        pos = longint'($signed(px.hue)) % DEG360;
        if (pos < 0) pos += DEG360;
        sec = t_sector'(pos / DEG60);
        off = pos % DEG60;
        r = ((pos / DEG60) % 2 == 1) ? DEG60 - off : off;
        s = px.sat;
        if (s > 256) s = 256;
        v = px.brt;
        top    = (v * 255) >> 8;
        bottom = (v * 255 * (256 - s)) >> 16;
        ramp   = (v * 255 * s * r) / (longint'(65536) * DEG60) + bottom;
        unique case (sec)
            SEC_R_TO_Y: begin rr = top;    gg = ramp;   bb = bottom; end
            SEC_Y_TO_G: begin rr = ramp;   gg = top;    bb = bottom; end
            SEC_G_TO_C: begin rr = bottom; gg = top;    bb = ramp;   end
            SEC_C_TO_B: begin rr = bottom; gg = ramp;   bb = top;    end
            SEC_B_TO_M: begin rr = ramp;   gg = bottom; bb = top;    end
            default:    begin rr = top;    gg = bottom; bb = ramp;   end
        endcase
        c.red   = clip_channel(rr);
        c.green = clip_channel(gg);
        c.blue  = clip_channel(bb);
        return c;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_fault(input hsv_t px, input rgb_t want, input rgb_t got, input bit orphan);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (orphan)
                $display("%0t: output transfer with nothing expected: r=%0d g=%0d b=%0d",
                         $realtime, got.red, got.green, got.blue);
            else
                $display("%0t: hue=%0d s=%0d v=%0d expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                         $realtime, $signed(px.hue), px.sat, px.brt,
                         want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        hsv_t     px;
        rgb_t     got;
        pending_t head;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                px = hsv_t'({s_axis_tdata[HUE_W-1:0],
                             s_axis_tdata[HUE_W+SAT_W-1 -: SAT_W],
                             s_axis_tdata[HUE_W+SAT_W+BRT_W-1 -: BRT_W]});
                pending_rgb.push_back('{pixel: px, color: hsv_to_rgb(px)});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = rgb_t'(m_axis_tdata[3*CH_W-1:0]);
                if (pending_rgb.size() == 0) begin
                    report_fault('0, '0, got, 1'b1);
                end else begin
                    head = pending_rgb.pop_front();
                    if (got.red !== head.color.red || got.green !== head.color.green ||
                        got.blue !== head.color.blue)
                        report_fault(head.pixel, head.color, got, 1'b0);
                end
            end
        end
    end

    // Stall the output side at random unless steady flow is requested.
    initial begin : sink
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady) begin
                stall_left = 0;
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [SAT_W-1:0] sat,
                              input logic [BRT_W-1:0] brt);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({brt, sat, hue});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random_pixel();
        logic [SAT_W-1:0] sat;
        logic [BRT_W-1:0] brt;
        sat = ($urandom_range(0, 99) < 85) ? SAT_W'($urandom_range(0, 256))
                                           : SAT_W'($urandom_range(257, 511));
        brt = ($urandom_range(0, 99) < 80) ? BRT_W'($urandom_range(0, 256))
                                           : BRT_W'($urandom_range(257, 511));
        send_pixel(HUE_W'($urandom), sat, brt);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        send_pixel(16'd0, 9'd0, 9'd0);
        send_pixel(16'd0, 9'd256, 9'd256);
        send_pixel(16'h8000, 9'd256, 9'd256);
        send_pixel(16'h7FFF, 9'd256, 9'd256);
        send_pixel(16'hFFFF, 9'd256, 9'd256);
        send_pixel(16'd959, 9'd256, 9'd256);
        send_pixel(16'd960, 9'd256, 9'd256);
        send_pixel(16'd1919, 9'd200, 9'd256);
        send_pixel(16'd1920, 9'd200, 9'd256);
        send_pixel(16'd2880, 9'd200, 9'd180);
        send_pixel(16'd3840, 9'd200, 9'd180);
        send_pixel(16'd4800, 9'd200, 9'd180);
        send_pixel(16'd5759, 9'd256, 9'd256);
        send_pixel(16'd5760, 9'd256, 9'd256);
        send_pixel(16'(-5760), 9'd100, 9'd256);
        send_pixel(16'd480, 9'd257, 9'd200);
        send_pixel(16'd480, 9'd511, 9'd511);
        send_pixel(16'd2400, 9'd128, 9'd511);
        send_pixel(16'd4000, 9'd0, 9'd300);
        send_pixel(16'd1440, 9'd100, 9'd257);
        send_pixel(16'd3360, 9'd200, 9'd100);
        send_pixel(16'd5280, 9'd511, 9'd0);
        send_pixel(16'h8000, 9'd0, 9'd511);
        send_pixel(16'(-1000), 9'd255, 9'd255);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (60) send_random_pixel();
        steady = 1'b0;
    endtask

    task automatic test_pause_until_empty();
        repeat (20) send_random_pixel();
        wait_drained();
        repeat (20) send_random_pixel();
    endtask

    task automatic test_random_mix();
        repeat (480) send_random_pixel();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_back_to_back();
        test_pause_until_empty();
        test_random_mix();

        wait_drained();
        repeat (4 * NSTAGE) @(posedge i_clk);
        if (pending_rgb.size() != 0) begin
            $display("%0d expected transfers never arrived", pending_rgb.size());
            mismatch_count += pending_rgb.size();
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
